>>> rtl/core/fbhq_pkg.sv
package fbhq_pkg;

    localparam int BIN_CAP    = 32;
    localparam int EDGE_BITS  = 32;
    localparam int TOTAL_BITS = 52;
    localparam int SCALE_BITS = 14;
    localparam int KIND_BITS  = 3;

    localparam logic [SCALE_BITS-1:0] SCALE     = 14'd10000;
    localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = {TOTAL_BITS{1'b1}};
    localparam logic [KIND_BITS-1:0]  LAST_KIND = 3'd4;

    // Ascending bin edges; past 4000 they keep doubling from 8000.
    localparam logic [EDGE_BITS-1:0] EDGE_TABLE [BIN_CAP] = '{
        32'd1, 32'd5, 32'd10, 32'd20, 32'd40, 32'd60, 32'd80, 32'd100,
        32'd200, 32'd400, 32'd600, 32'd1000, 32'd4000, 32'd8000, 32'd16000,
        32'd32000, 32'd64000, 32'd128000, 32'd256000, 32'd512000,
        32'd1024000, 32'd2048000, 32'd4096000, 32'd8192000, 32'd16384000,
        32'd32768000, 32'd65536000, 32'd131072000, 32'd262144000,
        32'd524288000, 32'd1048576000, 32'd2097152000
    };

    typedef enum logic [1:0] {
        CMD_RECORD = 2'd0,
        CMD_REPORT = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_REC_WR,
        ST_SUM_RD,
        ST_SUM_ADD,
        ST_Q_THR,
        ST_W_CHK,
        ST_W_ADD,
        ST_W_MUL,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_take;
        logic rd_en;
        logic rd_from_in;
        logic rec_write;
        logic clear_all;
        logic sum_init;
        logic sum_add;
        logic walk_init;
        logic thr_load;
        logic walk_add;
        logic mul_load;
        logic out_load;
        logic kind_step;
    } ctrl_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pos_last;
        logic walk_go;
        logic kind_last;
    } status_t;

    function automatic logic [EDGE_BITS-1:0] edge_of(input logic [4:0] idx);
        return EDGE_TABLE[idx];
    endfunction

    // Quantile levels in ten-thousandths.
    function automatic logic [SCALE_BITS-1:0] quant_of(input logic [KIND_BITS-1:0] kind);
        logic [SCALE_BITS-1:0] q;
        unique case (kind)
            3'd0:    q = 14'd9000;
            3'd1:    q = 14'd9900;
            3'd2:    q = 14'd9990;
            3'd3:    q = 14'd9999;
            default: q = 14'd10000;
        endcase
        return q;
    endfunction

endpackage

>>> rtl/core/fbhq_ram.sv
module fbhq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/fbhq_datapath.sv
module fbhq_datapath
    import fbhq_pkg::*;
#(
    parameter int NUM_BINS   = 13,
    parameter int COUNT_BITS = 48,
    parameter int VALUE_BITS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [31:0]           sample_value,
    input  logic [15:0]           sample_weight,
    input  ctrl_t                 ctrl,
    output status_t               status,
    output logic [KIND_BITS-1:0]  quantile_kind,
    output logic [EDGE_BITS-1:0]  edge_value,
    output logic [TOTAL_BITS-1:0] total_samples,
    output logic                  last_of_report
);

    localparam int IW     = $clog2(NUM_BINS);
    localparam int VW     = (VALUE_BITS < 32) ? VALUE_BITS : 32;
    localparam int SUM_W  = ((COUNT_BITS > TOTAL_BITS) ? COUNT_BITS : TOTAL_BITS) + 1;
    localparam int PROD_W = TOTAL_BITS + SCALE_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [31:0]            value_in;
    logic [IW-1:0]          bin_sel;
    logic [IW-1:0]          rd_addr;
    logic [COUNT_BITS-1:0]  rdata;
    logic [COUNT_BITS-1:0]  cnt;
    logic [COUNT_BITS:0]    rec_sum;
    logic [COUNT_BITS-1:0]  rec_new;
    logic [SUM_W-1:0]       tot_sum;
    logic [TOTAL_BITS-1:0]  tot_new;
    logic [SUM_W-1:0]       acc_sum;
    logic [TOTAL_BITS-1:0]  acc_new;

    logic [15:0]            weight_reg;
    logic [IW-1:0]          bin_reg;
    logic [IW-1:0]          raddr_reg;
    logic [NUM_BINS-1:0]    valid_reg;
    logic [IW-1:0]          pos_reg;
    logic [KIND_BITS-1:0]   kind_reg;
    logic [TOTAL_BITS-1:0]  total_reg;
    logic [TOTAL_BITS-1:0]  acc_reg;
    logic [PROD_W-1:0]      thr_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [KIND_BITS-1:0]   out_kind_reg;
    logic [EDGE_BITS-1:0]   out_edge_reg;
    logic [TOTAL_BITS-1:0]  out_total_reg;
    logic                   out_last_reg;

    assign value_in = 32'(sample_value[VW-1:0]);

    // First bin whose edge is at or above the value, else the last bin.
    always_comb
    begin
        bin_sel = IW'(NUM_BINS - 1);
        for (int i = NUM_BINS - 1; i >= 0; i--)
        begin
            if (edge_of(5'(i)) >= value_in)
            begin
                bin_sel = IW'(i);
            end
        end
    end

    assign rd_addr = ctrl.rd_from_in ? bin_sel : pos_reg;

    fbhq_ram #(
        .WIDTH (COUNT_BITS),
        .DEPTH (NUM_BINS)
    ) u_counts (
        .clk   (clk),
        .we    (ctrl.rec_write),
        .waddr (bin_reg),
        .wdata (rec_new),
        .re    (ctrl.rd_en),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    // A bin not written since the last clear reads as zero.
    assign cnt = valid_reg[raddr_reg] ? rdata : '0;

    assign rec_sum = {1'b0, cnt} + (COUNT_BITS + 1)'(weight_reg);
    assign rec_new = (rec_sum >= {1'b0, COUNT_MAX}) ? COUNT_MAX : rec_sum[COUNT_BITS-1:0];

    assign tot_sum = SUM_W'(total_reg) + SUM_W'(cnt);
    assign tot_new = (tot_sum >= SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : tot_sum[TOTAL_BITS-1:0];

    assign acc_sum = SUM_W'(acc_reg) + SUM_W'(cnt);
    assign acc_new = (acc_sum >= SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : acc_sum[TOTAL_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            pos_reg   <= '0;
            kind_reg  <= '0;
        end
        else
        begin
            if (ctrl.clear_all)
            begin
                valid_reg <= '0;
            end
            else if (ctrl.rec_write)
            begin
                valid_reg[bin_reg] <= 1'b1;
            end

            if (ctrl.sum_init || ctrl.walk_init)
            begin
                pos_reg <= '0;
            end
            else if (ctrl.sum_add || ctrl.walk_add)
            begin
                pos_reg <= pos_reg + IW'(1);
            end

            if (ctrl.walk_init)
            begin
                kind_reg <= '0;
            end
            else if (ctrl.kind_step)
            begin
                kind_reg <= kind_reg + KIND_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.in_take)
        begin
            weight_reg <= sample_weight;
            bin_reg    <= bin_sel;
        end
        if (ctrl.rd_en)
        begin
            raddr_reg <= rd_addr;
        end
        if (ctrl.sum_init)
        begin
            total_reg <= '0;
        end
        else if (ctrl.sum_add)
        begin
            total_reg <= tot_new;
        end
        if (ctrl.walk_init)
        begin
            acc_reg  <= '0;
            prod_reg <= '0;
        end
        else
        begin
            if (ctrl.walk_add)
            begin
                acc_reg <= acc_new;
            end
            if (ctrl.mul_load)
            begin
                prod_reg <= PROD_W'(acc_reg) * PROD_W'(SCALE);
            end
        end
        if (ctrl.thr_load)
        begin
            thr_reg <= PROD_W'(total_reg) * PROD_W'(quant_of(kind_reg));
        end
        if (ctrl.out_load)
        begin
            out_kind_reg  <= kind_reg;
            out_edge_reg  <= edge_of(5'(pos_reg));
            out_total_reg <= total_reg;
            out_last_reg  <= (kind_reg == LAST_KIND);
        end
    end

    assign status.pos_last  = (pos_reg == IW'(NUM_BINS - 1));
    assign status.walk_go   = (prod_reg < thr_reg);
    assign status.kind_last = (kind_reg == LAST_KIND);

    assign quantile_kind  = out_kind_reg;
    assign edge_value     = out_edge_reg;
    assign total_samples  = out_total_reg;
    assign last_of_report = out_last_reg;

endmodule

>>> rtl/core/fbhq_ctrl.sv
module fbhq_ctrl
    import fbhq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] command,
    output logic       out_valid,
    input  logic       out_ready,
    input  status_t    status,
    output ctrl_t      ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        ctrl       = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.in_take = 1'b1;
                    unique case (command)
                        CMD_RECORD:
                        begin
                            ctrl.rd_en      = 1'b1;
                            ctrl.rd_from_in = 1'b1;
                            state_next      = ST_REC_WR;
                        end
                        CMD_REPORT:
                        begin
                            ctrl.sum_init = 1'b1;
                            state_next    = ST_SUM_RD;
                        end
                        CMD_CLEAR:
                        begin
                            ctrl.clear_all = 1'b1;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_REC_WR:
            begin
                ctrl.rec_write = 1'b1;
                state_next     = ST_IDLE;
            end
            ST_SUM_RD:
            begin
                ctrl.rd_en = 1'b1;
                state_next = ST_SUM_ADD;
            end
            ST_SUM_ADD:
            begin
                ctrl.sum_add = 1'b1;
                if (status.pos_last)
                begin
                    ctrl.walk_init = 1'b1;
                    state_next     = ST_Q_THR;
                end
                else
                begin
                    state_next = ST_SUM_RD;
                end
            end
            ST_Q_THR:
            begin
                ctrl.thr_load = 1'b1;
                state_next    = ST_W_CHK;
            end
            ST_W_CHK:
            begin
                if (status.walk_go && !status.pos_last)
                begin
                    ctrl.rd_en = 1'b1;
                    state_next = ST_W_ADD;
                end
                else
                begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_OUT;
                end
            end
            ST_W_ADD:
            begin
                ctrl.walk_add = 1'b1;
                state_next    = ST_W_MUL;
            end
            ST_W_MUL:
            begin
                ctrl.mul_load = 1'b1;
                state_next    = ST_W_CHK;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    ctrl.kind_step = 1'b1;
                    state_next     = status.kind_last ? ST_IDLE : ST_Q_THR;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/fixed_bin_histogram_quantiles_top.sv
// Fixed-bin latency histogram with a quantile summary. Each input word carries a
// command: record adds sample_weight to the first bin whose built-in edge is at or
// above sample_value (values above every edge land in the last bin), report emits
// five output words (P90, P99, P99.9, P99.99 and max, kind 0 to 4 on tuser) with the
// reported bin edge and the saturated total count, and clear zeroes every counter.
// Command 3 is ignored. Counters saturate at 2^COUNT_BITS-1, the total and running
// sum at 2^52-1. The block handles one command at a time: a record is a registered
// counter read followed by the saturating write back, and a clear acts as the
// command is taken. The report time is set by the single read port of the counter
// memory, which the total pass and then the quantile walk go through one bin at a
// time, and by the scaled compare, whose multiply by 10000 is registered before
// each test. Counters are cleared at reset and on clear by per-bin valid flags, so
// no clearing pass is needed.
module fixed_bin_histogram_quantiles_top
    import fbhq_pkg::*;
#(
    parameter int NUM_BINS   = 13,
    parameter int COUNT_BITS = 48,
    parameter int VALUE_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // command[1:0], sample_value[33:2], sample_weight[49:34]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,   // edge_value[31:0], total_samples[83:32]
    output logic [2:0]  m_tuser,   // quantile_kind[2:0]
    output logic        m_tlast    // last_of_report
);

    ctrl_t                 ctrl;
    status_t               status;
    logic [EDGE_BITS-1:0]  edge_value;
    logic [TOTAL_BITS-1:0] total_samples;

    fbhq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .command   (s_tdata[1:0]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .ctrl      (ctrl)
    );

    fbhq_datapath #(
        .NUM_BINS   (NUM_BINS),
        .COUNT_BITS (COUNT_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_value   (s_tdata[33:2]),
        .sample_weight  (s_tdata[49:34]),
        .ctrl           (ctrl),
        .status         (status),
        .quantile_kind  (m_tuser),
        .edge_value     (edge_value),
        .total_samples  (total_samples),
        .last_of_report (m_tlast)
    );

    // The output word holds its payload in datapath registers until taken.
    assign m_tdata = {4'b0, total_samples, edge_value};

endmodule

>>> rtl/core/fbhq_checker.sv
module fbhq_checker
    import fbhq_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [87:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // Commands are served one at a time, so input and output never open together.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_tready && m_tvalid))
        else $error("input ready while a report word is pending");

    // The max word, and only it, closes a report.
    a_last_is_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser == LAST_KIND)))
        else $error("tlast does not match the max quantile");

    // After a word that does not close the report, the input stays closed.
    a_report_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> !s_tready)
        else $error("input reopened in the middle of a report");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=>
            (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled output word changed");

endmodule

bind fixed_bin_histogram_quantiles_top fbhq_checker u_fbhq_checker (.*);
